/* design/mhs_pkg.sv */
`default_nettype none
package mhs_pkg;
  localparam int DEPTH_DEF = 32;
  localparam int ID_W = 32;
  localparam int CH_W = 8;
  localparam int NODE_W = 32;
  localparam int TAG_W = 32;
  localparam int CNT_W = 7;
  localparam int FLAG_W = 10;
  localparam int REC_W = ID_W + NODE_W + NODE_W + TAG_W + FLAG_W;

  typedef enum logic [2:0] {
    REQ_ADD = 3'd0, REQ_ACK = 3'd1, REQ_READ = 3'd2, REQ_CHAN = 3'd3,
    REQ_DIRECT = 3'd4, REQ_ALL = 3'd5, REQ_CLEAR = 3'd6, REQ_BAD = 3'd7
  } req_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EVICT = 2'd1;
  localparam logic [1:0] ST_DUP = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_WRITE, S_EMIT_RD, S_EMIT_WAIT,
    S_EMIT_OUT, S_RESULT
  } state_t;
endpackage
`default_nettype wire

/* design/mhs_req_if.sv */
`default_nettype none
interface mhs_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] msg_id;
  logic [7:0]  channel;
  logic        direct_flag;
  logic [31:0] src_node;
  logic [31:0] to_node;
  logic        ack_in;
  logic [31:0] payload_tag;
  logic [5:0]  read_index;
  logic [6:0]  max_count;
  logic [31:0] query_node;
  modport source (output valid, req_type, msg_id, channel, direct_flag, src_node, to_node,
                  ack_in, payload_tag, read_index, max_count, query_node, input ready);
  modport sink (input valid, req_type, msg_id, channel, direct_flag, src_node, to_node,
                ack_in, payload_tag, read_index, max_count, query_node, output ready);
endinterface
`default_nettype wire

/* design/mhs_res_if.sv */
`default_nettype none
interface mhs_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] out_id;
  logic [7:0]  out_channel;
  logic        out_direct;
  logic [31:0] out_from;
  logic [31:0] out_to;
  logic        out_acked;
  logic [31:0] out_tag;
  logic [6:0]  stored_count;
  logic        last;
  modport source (output valid, status, out_id, out_channel, out_direct, out_from, out_to,
                  out_acked, out_tag, stored_count, last, input ready);
  modport sink (input valid, status, out_id, out_channel, out_direct, out_from, out_to,
                out_acked, out_tag, stored_count, last, output ready);
endinterface
`default_nettype wire

/* design/message_history_store.sv */
// Sequence: add scans the held records for a duplicate id, then writes the new record;
// ack scans the same way and sets the acked flag on a hit; read fetches one record.
// Queries: a backward scan from the newest record counts matches, then a forward pass
// emits the matching records and skips the others; clear and bad requests answer directly.
// Throughput: one request at a time; in.ready is high only when idle.
// Reset (rst, synchronous) empties the store; record memory keeps no reset.
`default_nettype none
module message_history_store
  import mhs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  mhs_req_if.sink   in,
  mhs_res_if.source out
);
  localparam int AW = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  state_t state, state_next;
  logic [AW-1:0]    oldest_ptr;
  logic [CNT_W-1:0] held_count;

  // latched request
  req_t             rq;
  logic [ID_W-1:0]  r_id;
  logic [CH_W-1:0]  r_ch;
  logic             r_dir, r_ack;
  logic [NODE_W-1:0] r_from, r_to, r_node;
  logic [TAG_W-1:0] r_tag;
  logic [CNT_W-1:0] r_maxc;

  // scan position (from oldest), match counter, emit counter
  logic [CNT_W-1:0] pos, nmatch, nleft;
  logic [1:0]       res_status;
  logic             hit;

  // memory
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [REC_W-1:0] wdata, rdata;

  mhs_ram #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // record fields of the read word
  logic [ID_W-1:0]   m_id;
  logic [NODE_W-1:0] m_from, m_to;
  logic [TAG_W-1:0]  m_tag;
  logic [FLAG_W-1:0] m_flag;
  assign {m_id, m_from, m_to, m_tag, m_flag} = rdata;

  // slot of a position: (oldest + p) mod DEPTH, valid while oldest + p < 2*DEPTH
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CNT_W-1:0] p);
    logic [CNT_W:0] s;
    s = {{(CNT_W+1-AW){1'b0}}, base} + {1'b0, p};
    if (s >= (CNT_W+1)'(DEPTH)) s = s - (CNT_W+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  // shared compare unit
  logic match;
  always_comb begin
    unique case (rq)
      REQ_CHAN:   match = !m_flag[8] && (m_flag[7:0] == r_ch);
      REQ_DIRECT: match = m_flag[8] && ((m_from == r_node) || (m_to == r_node));
      REQ_ALL:    match = 1'b1;
      default:    match = (m_id == r_id);
    endcase
  end

  logic is_query;
  assign is_query = (rq == REQ_CHAN) || (rq == REQ_DIRECT) || (rq == REQ_ALL);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in.valid) begin
        unique case (req_t'(in.req_type))
          REQ_ADD: state_next = (in.msg_id != '0 && held_count != '0) ? S_SCAN_RD : S_WRITE;
          REQ_ACK: state_next = (in.msg_id != '0 && held_count != '0) ? S_SCAN_RD : S_RESULT;
          REQ_READ: state_next = ({1'b0, in.read_index} < held_count) ? S_EMIT_RD : S_RESULT;
          REQ_CHAN, REQ_DIRECT, REQ_ALL:
            state_next = (held_count != '0 && in.max_count != '0) ? S_SCAN_RD : S_RESULT;
          default: state_next = S_RESULT;
        endcase
      end
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (is_query) begin
          if (match && (nmatch + 1'b1 == r_maxc)) state_next = S_EMIT_RD;
          else if (pos == '0) state_next = (nmatch != '0 || match) ? S_EMIT_RD : S_RESULT;
          else state_next = S_SCAN_RD;
        end else if (match) begin
          state_next = (rq == REQ_ACK) ? S_WRITE : S_RESULT;
        end else if (pos + 1'b1 == held_count) begin
          state_next = (rq == REQ_ADD) ? S_WRITE : S_RESULT;
        end else state_next = S_SCAN_RD;
      end
      S_WRITE: state_next = S_RESULT;
      S_EMIT_RD: state_next = S_EMIT_WAIT;
      S_EMIT_WAIT: state_next = (is_query && !match) ? S_EMIT_RD : S_EMIT_OUT;
      S_EMIT_OUT: if (out.ready) state_next = (nleft == 7'd1 || !is_query) ? S_IDLE : S_EMIT_RD;
      S_RESULT: if (out.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // query scan steps back; ack/add steps forward; emit goes forward
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_ptr <= '0;
      held_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in.valid) begin
          rq <= req_t'(in.req_type);
          r_id <= in.msg_id; r_ch <= in.channel; r_dir <= in.direct_flag;
          r_from <= in.src_node; r_to <= in.to_node; r_ack <= in.ack_in;
          r_tag <= in.payload_tag; r_maxc <= in.max_count;
          r_node <= in.query_node;
          nmatch <= '0;
          res_status <= (req_t'(in.req_type) == REQ_ADD || req_t'(in.req_type) == REQ_CLEAR)
                        ? ST_OK : ST_NONE;
          hit <= 1'b0;
          unique case (req_t'(in.req_type))
            REQ_CHAN, REQ_DIRECT, REQ_ALL: pos <= held_count - 1'b1;
            REQ_READ: begin pos <= {1'b0, in.read_index}; nleft <= 7'd1; end
            REQ_CLEAR: begin held_count <= '0; oldest_ptr <= '0; end
            default: pos <= '0;
          endcase
        end
        S_SCAN_CHK: begin
          if (is_query) begin
            if (match) nmatch <= nmatch + 1'b1;
            if (match && (nmatch + 1'b1 == r_maxc)) nleft <= nmatch + 1'b1;
            else if (pos == '0) nleft <= nmatch + (match ? 7'd1 : 7'd0);
            else pos <= pos - 1'b1;
          end else if (match) begin
            hit <= 1'b1;
            res_status <= (rq == REQ_ADD) ? ST_DUP : ST_OK;
          end else if (pos + 1'b1 != held_count) pos <= pos + 1'b1;
        end
        S_WRITE: if (rq == REQ_ADD) begin
          if (held_count >= DEPTH_C) begin
            oldest_ptr <= slot_of(oldest_ptr, 7'd1);
            res_status <= ST_EVICT;
          end else held_count <= held_count + 1'b1;
        end
        S_EMIT_OUT: if (out.ready && is_query) begin
          nleft <= nleft - 1'b1;
          pos <= pos + 1'b1;
          // step to the next record; non-matching ones are skipped in S_EMIT_WAIT
        end
        default: ;
      endcase
      // skip non-matching words during the forward pass
      if (state == S_EMIT_WAIT && is_query && !match) pos <= pos + 1'b1;
    end
  end

  // memory port control
  always_comb begin
    raddr = slot_of(oldest_ptr, pos);
    we = 1'b0;
    waddr = raddr;
    wdata = rdata;
    if (state == S_WRITE && rq == REQ_ADD) begin
      we = 1'b1;
      waddr = (held_count >= DEPTH_C) ? oldest_ptr : slot_of(oldest_ptr, held_count);
      wdata = {r_id, r_from, r_to, r_tag, r_ack, r_dir, r_ch};
    end else if (state == S_WRITE) begin
      we = hit;
      wdata = {m_id, m_from, m_to, m_tag, 1'b1, m_flag[8:0]};
    end
  end

  // emit-wait loops back on non-match
  logic emit_ok;
  assign emit_ok = (state == S_EMIT_OUT);

  assign in.ready = (state == S_IDLE);
  assign out.valid = emit_ok || (state == S_RESULT);
  assign out.status = emit_ok ? ST_OK : res_status;
  assign out.out_id = emit_ok ? m_id : '0;
  assign out.out_channel = emit_ok ? m_flag[7:0] : '0;
  assign out.out_direct = emit_ok ? m_flag[8] : 1'b0;
  assign out.out_from = emit_ok ? m_from : '0;
  assign out.out_to = emit_ok ? m_to : '0;
  assign out.out_acked = emit_ok ? m_flag[9] : 1'b0;
  assign out.out_tag = emit_ok ? m_tag : '0;
  assign out.stored_count = held_count;
  assign out.last = emit_ok ? (nleft == 7'd1 || !is_query) : 1'b1;
endmodule
`default_nettype wire

/* design/mhs_ram.sv */
`default_nettype none
module mhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/mhs_checker.sv */
`default_nettype none
module mhs_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_last,
  input wire logic [6:0] stored_count
);
  a_cnt: assert property (@(posedge clk) disable iff (rst) stored_count <= 7'd64)
    else $error("count too large");
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("word dropped");
  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> !in_ready) else $error("early ready");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready right after accept");
endmodule
bind message_history_store mhs_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready), .out_last(out.last),
  .stored_count(out.stored_count)
);
`default_nettype wire

/* test/tb_message_history_store.sv */
`default_nettype none
module tb_message_history_store;
  import mhs_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] msg_id;
    logic [7:0]  channel;
    logic        direct_flag;
    logic [31:0] src_node;
    logic [31:0] to_node;
    logic        ack_in;
    logic [31:0] payload_tag;
    logic [5:0]  read_index;
    logic [6:0]  max_count;
    logic [31:0] query_node;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_id;
    logic [7:0]  out_channel;
    logic        out_direct;
    logic [31:0] out_from;
    logic [31:0] out_to;
    logic        out_acked;
    logic [31:0] out_tag;
    logic [6:0]  stored_count;
    logic        last;
  } record_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit rst_done = 1'b0;

  mhs_req_if req_bus ();
  mhs_res_if res_bus ();

  message_history_store #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .in(req_bus.sink), .out(res_bus.source)
  );

  always #4 clk = ~clk;

  // Shadow copy of the history
  logic [31:0] sh_id [DEPTH];
  logic [31:0] sh_from [DEPTH];
  logic [31:0] sh_to [DEPTH];
  logic [31:0] sh_tag [DEPTH];
  logic [7:0]  sh_chan [DEPTH];
  logic        sh_dir [DEPTH];
  logic        sh_acked [DEPTH];
  int          sh_oldest;
  int          sh_held;

  record_word_t expected_words[$];
  int  error_count;
  int  idle_cycles;
  bit  rx_stall_on;

  function automatic int slot_at(int pos);
    return (sh_oldest + pos) % DEPTH;
  endfunction

  function automatic record_word_t empty_word(logic [1:0] st);
    record_word_t w;
    w = '0;
    w.status = st;
    w.stored_count = 7'(sh_held);
    w.last = 1'b1;
    return w;
  endfunction

  function automatic record_word_t slot_word(int s, logic lst);
    record_word_t w;
    w = '0;
    w.status = ST_OK;
    w.out_id = sh_id[s];
    w.out_channel = sh_chan[s];
    w.out_direct = sh_dir[s];
    w.out_from = sh_from[s];
    w.out_to = sh_to[s];
    w.out_acked = sh_acked[s];
    w.out_tag = sh_tag[s];
    w.stored_count = 7'(sh_held);
    w.last = lst;
    return w;
  endfunction

  // Queue one expected result word at the tail
  function automatic void expect_word(record_word_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  // Apply one request to the shadow history and queue the words it produces
  task automatic predict_history(request_t r);
    int s;
    int n;
    int sel[$];
    logic [1:0] st;
    bit hit;
    n = 0;
    case (r.req_type)
      REQ_ADD: begin
        hit = 1'b0;
        if (r.msg_id != 0)
          for (int i = 0; i < sh_held; i++)
            if (sh_id[slot_at(i)] == r.msg_id) hit = 1'b1;
        if (hit) begin
          expect_word(empty_word(ST_DUP));
        end else begin
          if (sh_held >= DEPTH) begin
            s = sh_oldest;
            sh_oldest = (sh_oldest + 1) % DEPTH;
            st = ST_EVICT;
          end else begin
            s = slot_at(sh_held);
            sh_held++;
            st = ST_OK;
          end
          sh_id[s] = r.msg_id;
          sh_from[s] = r.src_node;
          sh_to[s] = r.to_node;
          sh_tag[s] = r.payload_tag;
          sh_chan[s] = r.channel;
          sh_dir[s] = r.direct_flag;
          sh_acked[s] = r.ack_in;
          expect_word(empty_word(st));
        end
      end
      REQ_ACK: begin
        st = ST_NONE;
        if (r.msg_id != 0)
          for (int i = 0; i < sh_held; i++) begin
            s = slot_at(i);
            if (st == ST_NONE && sh_id[s] == r.msg_id) begin
              sh_acked[s] = 1'b1;
              st = ST_OK;
            end
          end
        expect_word(empty_word(st));
      end
      REQ_READ: begin
        if (int'(r.read_index) < sh_held)
          expect_word(slot_word(slot_at(int'(r.read_index)), 1'b1));
        else
          expect_word(empty_word(ST_NONE));
      end
      REQ_CHAN, REQ_DIRECT, REQ_ALL: begin
        for (int i = sh_held - 1; i >= 0 && n < int'(r.max_count); i--) begin
          s = slot_at(i);
          if ((r.req_type == REQ_ALL) ||
              (r.req_type == REQ_CHAN && !sh_dir[s] && sh_chan[s] == r.channel) ||
              (r.req_type == REQ_DIRECT && sh_dir[s] &&
               (sh_from[s] == r.query_node || sh_to[s] == r.query_node))) begin
            sel.push_front(s);
            n++;
          end
        end
        if (n == 0) expect_word(empty_word(ST_NONE));
        for (int k = 0; k < n; k++)
          expect_word(slot_word(sel[k], k == n - 1));
      end
      REQ_CLEAR: begin
        sh_held = 0;
        sh_oldest = 0;
        expect_word(empty_word(ST_OK));
      end
      default: expect_word(empty_word(ST_NONE));
    endcase
  endtask

  task automatic report_mismatch(string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic int gap_length();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(5, 30);
  endfunction

  // Send one request word and predict its results on acceptance;
  // returns at the accepting edge with valid still high
  task automatic send_request(request_t r);
    int gap;
    gap = gap_length();
    @(negedge clk);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid <= 1'b1;
    {req_bus.req_type, req_bus.msg_id, req_bus.channel, req_bus.direct_flag,
     req_bus.src_node, req_bus.to_node, req_bus.ack_in, req_bus.payload_tag,
     req_bus.read_index, req_bus.max_count, req_bus.query_node} <= r;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    predict_history(r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic request_t blank_request(logic [2:0] kind);
    request_t r;
    r = '0;
    r.req_type = kind;
    return r;
  endfunction

  function automatic request_t add_request(logic [31:0] id, logic [7:0] ch, logic dir,
                                           logic [31:0] src, logic [31:0] dst);
    request_t r;
    r = blank_request(REQ_ADD);
    r.msg_id = id;
    r.channel = ch;
    r.direct_flag = dir;
    r.src_node = src;
    r.to_node = dst;
    r.ack_in = 1'($urandom_range(0, 1));
    r.payload_tag = $urandom;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    r = '0;
    r.req_type = ($urandom_range(0, 19) == 0) ? 3'(REQ_BAD) : 3'($urandom_range(0, 6));
    if ($urandom_range(0, 9) < 5) r.req_type = REQ_ADD;
    if (r.req_type == REQ_CLEAR && $urandom_range(0, 3) != 0) r.req_type = REQ_ALL;
    // Small pools so duplicates, acks and query matches happen often
    r.msg_id = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 40));
    r.channel = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    r.direct_flag = 1'($urandom_range(0, 1));
    r.src_node = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(1, 4));
    r.to_node = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(1, 4));
    r.ack_in = 1'($urandom_range(0, 1));
    r.payload_tag = $urandom;
    r.read_index = 6'($urandom);
    r.max_count = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 8));
    r.query_node = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(1, 4));
    return r;
  endfunction

  // Basic ops on an empty and a small store, plus field extremes
  task automatic test_directed_basics();
    request_t r;
    send_request(blank_request(REQ_READ));
    send_request(blank_request(REQ_ALL));
    send_request(add_request(32'hFFFF_FFFF, 8'hFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(add_request(32'h0, 8'h00, 1'b1, 32'h0, 32'h7));
    send_request(add_request(32'h0, 8'h00, 1'b1, 32'h7, 32'h0));
    send_request(add_request(32'hFFFF_FFFF, 8'h01, 1'b0, 32'h1, 32'h2));
    send_request(add_request(32'h5, 8'hFF, 1'b0, 32'h1, 32'h2));
    r = blank_request(REQ_ACK);
    r.msg_id = 32'h5;
    send_request(r);
    r.msg_id = 32'h0;
    send_request(r);
    r.msg_id = 32'h1234;
    send_request(r);
    r = blank_request(REQ_READ);
    r.read_index = 6'd4;
    send_request(r);
    r.read_index = 6'd63;
    send_request(r);
    r = blank_request(REQ_CHAN);
    r.channel = 8'hFF;
    r.max_count = 7'd64;
    send_request(r);
    r.max_count = 7'd0;
    send_request(r);
    r = blank_request(REQ_DIRECT);
    r.query_node = 32'h0;
    r.max_count = 7'd1;
    send_request(r);
    r.max_count = 7'd64;
    send_request(r);
    r = blank_request(REQ_ALL);
    r.max_count = 7'd64;
    send_request(r);
    send_request(blank_request(REQ_BAD));
    send_request(blank_request(REQ_CLEAR));
  endtask

  // Fill past capacity so the oldest records are evicted
  task automatic test_eviction();
    request_t r;
    for (int i = 0; i < DEPTH + 3; i++)
      send_request(add_request(32'(1000 + i), 8'(i % 3), 1'(i % 2), 32'(i % 4), 32'h9));
    r = blank_request(REQ_ALL);
    r.max_count = 7'd64;
    send_request(r);
    wait_drained();
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 120; i++) begin
      send_request(random_request());
      if (i == 60) wait_drained();
    end
  endtask

  // Result side: random stalls and field-by-field compare
  always @(negedge clk) begin
    if (!rst_done) res_bus.ready <= 1'b0;
    else if ($urandom_range(0, 99) == 0) rx_stall_on <= ~rx_stall_on;
    else res_bus.ready <= rx_stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  always @(posedge clk) begin
    record_word_t got;
    record_word_t want;
    if (!rst) begin
      if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (res_bus.valid && res_bus.ready) begin
        got = {res_bus.status, res_bus.out_id, res_bus.out_channel, res_bus.out_direct,
               res_bus.out_from, res_bus.out_to, res_bus.out_acked, res_bus.out_tag,
               res_bus.stored_count, res_bus.last};
        if (expected_words.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = expected_words[0];
          expected_words.delete(0);
          if (got.status != want.status) report_mismatch("status");
          if (got.out_id != want.out_id) report_mismatch("out_id");
          if (got.out_channel != want.out_channel) report_mismatch("out_channel");
          if (got.out_direct != want.out_direct) report_mismatch("out_direct");
          if (got.out_from != want.out_from) report_mismatch("out_from");
          if (got.out_to != want.out_to) report_mismatch("out_to");
          if (got.out_acked != want.out_acked) report_mismatch("out_acked");
          if (got.out_tag != want.out_tag) report_mismatch("out_tag");
          if (got.stored_count != want.stored_count) report_mismatch("stored_count");
          if (got.last != want.last) report_mismatch("last");
        end
      end
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    error_count = 0;
    idle_cycles = 0;
    rx_stall_on = 1'b0;
    sh_oldest = 0;
    sh_held = 0;
    req_bus.valid = 1'b0;
    {req_bus.req_type, req_bus.msg_id, req_bus.channel, req_bus.direct_flag,
     req_bus.src_node, req_bus.to_node, req_bus.ack_in, req_bus.payload_tag,
     req_bus.read_index, req_bus.max_count, req_bus.query_node} = '0;
    res_bus.ready = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;
    rst_done = 1'b1;
    test_directed_basics();
    test_eviction();
    test_random_mix();
    wait_drained();
    repeat (5 * DEPTH) @(negedge clk);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
